// File: rtl/tct_pkg.sv
// Shared types and constants for the terminal cursor tracker.
// Used by tct_cfg_regs, tct_step and terminal_cursor_tracker; no dependencies.
`default_nettype none

package tct_pkg;

	localparam int unsigned POS_W = 8;
	localparam int unsigned LEN_W = 8;

	// Byte codes
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_ESC   = 8'h1B;
	localparam logic [7:0] CH_CSI   = 8'h5B; // '['
	localparam logic [7:0] CH_TWO   = 8'h32; // '2'
	localparam logic [7:0] CH_HOME  = 8'h48; // 'H'
	localparam logic [7:0] CH_CLEAR = 8'h4A; // 'J'
	localparam logic [7:0] CH_UP    = 8'h41; // 'A'
	localparam logic [7:0] CH_DOWN  = 8'h42; // 'B'
	localparam logic [7:0] CH_RIGHT = 8'h43; // 'C'
	localparam logic [7:0] CH_LEFT  = 8'h44; // 'D'

	// Register indexes (paddr[2])
	localparam logic REG_ROWS = 1'b0;
	localparam logic REG_COLS = 1'b1;

	localparam logic [7:0] ROWS_RESET = 8'd25;
	localparam logic [7:0] COLS_RESET = 8'd80;

	typedef struct packed {
		logic [7:0] rows;
		logic [7:0] cols;
	} cfg_t;

	typedef struct packed {
		logic [POS_W-1:0] col;
		logic [POS_W-1:0] row;
		logic             pending;
		logic [LEN_W-1:0] len;
		logic [7:0]       first;
		logic [7:0]       second;
		logic [7:0]       last;
	} state_t;

	typedef struct packed {
		logic             draw_valid;
		logic [7:0]       draw_byte;
		logic [POS_W-1:0] draw_col;
		logic [POS_W-1:0] draw_row;
		logic             scroll_up;
		logic             clear_request;
		logic [POS_W-1:0] cursor_col_out;
		logic [POS_W-1:0] cursor_row_out;
	} result_t;

endpackage

`default_nettype wire

// File: rtl/tct_cfg_regs.sv
// APB-style configuration registers (screen rows and columns).
// Depends on tct_pkg.
`default_nettype none

module tct_cfg_regs (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [2:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic      [31:0]  prdata,
	output logic              pready,
	output tct_pkg::cfg_t     cfg
);

	tct_pkg::cfg_t cfg_q;
	logic          wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rows <= tct_pkg::ROWS_RESET;
			cfg_q.cols <= tct_pkg::COLS_RESET;
		end else if (wr_en) begin
			unique case (paddr[2])
				tct_pkg::REG_ROWS: cfg_q.rows <= pwdata[7:0];
				tct_pkg::REG_COLS: cfg_q.cols <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			tct_pkg::REG_ROWS: prdata = {24'd0, cfg_q.rows};
			tct_pkg::REG_COLS: prdata = {24'd0, cfg_q.cols};
			default:           prdata = 32'd0;
		endcase
	end

endmodule

`default_nettype wire

// File: rtl/tct_step.sv
// Next-state and result logic for one terminal byte.
// Depends on tct_pkg.
`default_nettype none

module tct_step #(
	parameter int unsigned SEQ_LIMIT = 31
) (
	input  wire logic [7:0]      char_in,
	input  wire logic            end_of_write,
	input  tct_pkg::state_t      state,
	input  tct_pkg::cfg_t        cfg,
	output tct_pkg::state_t      state_nxt,
	output tct_pkg::result_t     result
);

	logic [7:0] row_max;
	logic [7:0] col_max;

	assign row_max = (cfg.rows == 8'd0) ? 8'd0 : cfg.rows - 8'd1;
	assign col_max = (cfg.cols == 8'd0) ? 8'd0 : cfg.cols - 8'd1;

	function automatic logic seq_clears(input tct_pkg::state_t s);
		return (s.len != '0) && (s.first == tct_pkg::CH_CSI) &&
			(s.last == tct_pkg::CH_CLEAR) && (s.len >= tct_pkg::LEN_W'(2)) &&
			(s.second == tct_pkg::CH_TWO);
	endfunction

	// Apply the cursor move of a finished sequence.
	function automatic tct_pkg::state_t seq_act(input tct_pkg::state_t s,
			input logic [7:0] rmax, input logic [7:0] cmax);
		tct_pkg::state_t r;
		r = s;
		if (s.len != '0 && s.first == tct_pkg::CH_CSI) begin
			case (s.last)
				tct_pkg::CH_HOME: begin
					r.col = '0;
					r.row = '0;
				end
				tct_pkg::CH_CLEAR: begin
					if (seq_clears(s)) begin
						r.col = '0;
						r.row = '0;
					end
				end
				tct_pkg::CH_UP:    if (s.row != '0) r.row = s.row - 8'd1;
				tct_pkg::CH_DOWN:  if (s.row < rmax) r.row = s.row + 8'd1;
				tct_pkg::CH_RIGHT: if (s.col < cmax) r.col = s.col + 8'd1;
				tct_pkg::CH_LEFT:  if (s.col != '0) r.col = s.col - 8'd1;
				default: ;
			endcase
		end
		return r;
	endfunction

	always_comb begin
		tct_pkg::state_t s;
		logic [8:0] nxt_row;
		logic [8:0] nxt_col;
		logic       scroll;
		logic       clr;
		logic       draw;
		logic       do_line;

		s       = state;
		scroll  = 1'b0;
		clr     = 1'b0;
		draw    = 1'b0;
		do_line = 1'b0;
		nxt_col = 9'd0;

		if (state.pending) begin
			if (char_in == tct_pkg::CH_ESC) begin
				clr       = seq_clears(s);
				s         = seq_act(s, row_max, col_max);
				s.pending = ~end_of_write;
				s.len     = '0;
				s.first   = '0;
				s.second  = '0;
				s.last    = '0;
			end else begin
				if (s.len == tct_pkg::LEN_W'(0)) s.first = char_in;
				if (s.len == tct_pkg::LEN_W'(1)) s.second = char_in;
				if (s.len < tct_pkg::LEN_W'(SEQ_LIMIT)) begin
					s.last = char_in;
					s.len  = s.len + tct_pkg::LEN_W'(1);
				end
				if (end_of_write) begin
					clr       = seq_clears(s);
					s         = seq_act(s, row_max, col_max);
					s.pending = 1'b0;
				end
			end
		end else begin
			case (char_in)
				tct_pkg::CH_ESC: begin
					if (!end_of_write) begin
						s.pending = 1'b1;
						s.len     = '0;
						s.first   = '0;
						s.second  = '0;
						s.last    = '0;
					end
				end
				tct_pkg::CH_LF: begin
					s.col   = '0;
					do_line = 1'b1;
				end
				tct_pkg::CH_CR: s.col = '0;
				tct_pkg::CH_BS: if (s.col != '0) s.col = s.col - 8'd1;
				tct_pkg::CH_TAB: begin
					nxt_col = ({1'b0, s.col} + 9'd8) & ~9'd7;
					s.col   = (nxt_col > {1'b0, col_max}) ? col_max : nxt_col[7:0];
				end
				default: begin
					draw    = 1'b1;
					nxt_col = {1'b0, s.col} + 9'd1;
					if (nxt_col > {1'b0, col_max}) begin
						s.col   = '0;
						do_line = 1'b1;
					end else begin
						s.col = nxt_col[7:0];
					end
				end
			endcase
		end

		// Line advance: scroll at the bottom and pin to the last row.
		nxt_row = {1'b0, s.row} + 9'd1;
		if (do_line) begin
			if (nxt_row > {1'b0, row_max}) begin
				scroll = 1'b1;
				s.row  = row_max;
			end else begin
				s.row = nxt_row[7:0];
			end
		end

		state_nxt              = s;
		result.draw_valid      = draw;
		result.draw_byte       = draw ? char_in : 8'd0;
		result.draw_col        = draw ? state.col : '0;
		result.draw_row        = draw ? state.row : '0;
		result.scroll_up       = scroll;
		result.clear_request   = clr;
		result.cursor_col_out  = s.col;
		result.cursor_row_out  = s.row;
	end

endmodule

`default_nettype wire

// File: rtl/terminal_cursor_tracker.sv
// Top level of the terminal cursor tracker: input register, step logic, result register.
// Depends on tct_pkg, tct_cfg_regs and tct_step.
`default_nettype none

// Terminal cursor tracker. Feed terminal output bytes on the s_ stream, one per beat, with
// s_tlast marking the last byte of a write call. Every input beat yields exactly one result
// beat on the m_ stream: the glyph to draw (if any) with its position, scroll and clear
// requests, and the cursor position after the byte. The block takes one beat per clock while
// the output side keeps accepting; a beat waits in the input register, the step logic runs
// on it there, and the result lands in the output register that drives m_tvalid. A stalled
// output register holds the next beat in the input register and drops s_tready.
// Cursor and escape-sequence state update as a beat leaves the input register, so
// back-to-back bytes see each other's effects. Screen size is set over the APB port
// (rows at 0x0, cols at 0x4, low byte used); write it only while idle.
module terminal_cursor_tracker #(
	parameter int unsigned SEQ_LIMIT = 31
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Input stream: tdata = char_in[7:0]; tlast = end_of_write
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,
	input  wire logic        s_tlast,
	// Output stream: tdata = draw_byte[7:0], draw_col[15:8], draw_row[23:16],
	// scroll_up[24], clear_request[25], cursor_col_out[33:26],
	// cursor_row_out[41:34], zero [47:42]; tuser = draw_valid
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata,
	output logic             m_tuser,
	// Configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);

	tct_pkg::cfg_t    cfg;
	tct_pkg::state_t  state_q;
	tct_pkg::state_t  state_nxt;
	tct_pkg::result_t result;
	tct_pkg::result_t res_s2;

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       eow_s1;
	logic       valid_s2;
	logic       advance;

	tct_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tct_step #(
		.SEQ_LIMIT (SEQ_LIMIT)
	) u_step (
		.char_in      (char_s1),
		.end_of_write (eow_s1),
		.state        (state_q),
		.cfg          (cfg),
		.state_nxt    (state_nxt),
		.result       (result)
	);

	// Move the held beat forward whenever the output register is free or draining.
	assign advance  = valid_s1 & (~valid_s2 | m_tready);
	assign s_tready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Payload: hold while stalled, capture on every accepted beat.
	always_ff @(posedge clk) begin
		if (s_tvalid & s_tready) begin
			char_s1 <= s_tdata;
			eow_s1  <= s_tlast;
		end
	end

	// Cursor and sequence state advance with each processed beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= result;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = res_s2.draw_valid;
	assign m_tdata  = {6'd0, res_s2.cursor_row_out, res_s2.cursor_col_out,
		res_s2.clear_request, res_s2.scroll_up, res_s2.draw_row, res_s2.draw_col,
		res_s2.draw_byte};

endmodule

`default_nettype wire

// File: sim/terminal_cursor_tracker_tb.sv
// Self-checking testbench for terminal_cursor_tracker: streams terminal bytes in, checks every
// result beat against a cycle-free cursor/escape tracker kept here, and programs the screen size.
// Depends on tct_pkg and the terminal_cursor_tracker RTL only.
`timescale 1ns / 1ps

module terminal_cursor_tracker_tb;

	localparam int unsigned SEQ_CAP   = 31;
	localparam int unsigned IDLE_LIMIT = 2000;  // cycles without any beat before giving up
	localparam int unsigned HOLD_LEN  = 60;     // long output stall to back the block up

	typedef struct packed {
		logic [7:0] ch;
		logic       eow;
	} term_byte_t;

	// Clock, reset and block ports; every input starts at a known value.
	logic        clk;
	logic        arst_n  = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'd0;   // char_in[7:0]
	logic        s_tlast = 1'b0;   // end_of_write
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;          // draw_byte, draw_col, draw_row, scroll_up, clear_request,
	                               // cursor_col_out, cursor_row_out, zero pad (low bit up)
	logic        m_tuser;          // draw_valid
	logic        psel    = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite  = 1'b0;
	logic [2:0]  paddr   = 3'd0;
	logic [31:0] pwdata  = 32'd0;
	logic [31:0] prdata;
	logic        pready;

	terminal_cursor_tracker #(.SEQ_LIMIT(SEQ_CAP)) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Tracker state mirrored in the testbench. Only touched when a byte is
	// accepted or a size register is written, so it stays in step with the
	// block no matter how the handshakes are spread out.
	// ------------------------------------------------------------------
	logic [7:0] rows_cfg = tct_pkg::ROWS_RESET;
	logic [7:0] cols_cfg = tct_pkg::COLS_RESET;
	logic [7:0] cur_col = 8'd0;
	logic [7:0] cur_row = 8'd0;
	logic       in_seq = 1'b0;
	logic [7:0] seq_len = 8'd0;
	logic [7:0] seq_first = 8'd0;
	logic [7:0] seq_second = 8'd0;
	logic [7:0] seq_last = 8'd0;

	// Expected result beats, oldest first, and the bytes still to be sent.
	tct_pkg::result_t cursor_reports[$];
	term_byte_t       tx_bytes[$];

	int unsigned queued_bytes = 0;
	int unsigned accepted_bytes = 0;
	int unsigned results_seen = 0;
	int unsigned mismatches = 0;
	int unsigned glyphs = 0;
	int unsigned scrolls = 0;
	int unsigned clears = 0;
	int unsigned size_writes = 0;
	bit          steady = 1'b0;   // no idling on either side while set

	// A zero-sized screen behaves as one row / one column.
	function automatic int eff_rows();
		return (rows_cfg == 8'd0) ? 1 : int'(rows_cfg);
	endfunction

	function automatic int eff_cols();
		return (cols_cfg == 8'd0) ? 1 : int'(cols_cfg);
	endfunction

	// Drop one row; pin to the bottom row and ask for a scroll when past it.
	function automatic bit line_down();
		int r;
		r = int'(cur_row) + 1;
		if (r >= eff_rows()) begin
			cur_row = 8'(eff_rows() - 1);
			return 1'b1;
		end
		cur_row = 8'(r);
		return 1'b0;
	endfunction

	function automatic void open_seq();
		in_seq     = 1'b1;
		seq_len    = 8'd0;
		seq_first  = 8'd0;
		seq_second = 8'd0;
		seq_last   = 8'd0;
	endfunction

	// Act on a finished sequence; returns the clear request.
	function automatic bit apply_seq();
		if (seq_len == 8'd0 || seq_first != tct_pkg::CH_CSI)
			return 1'b0;
		case (seq_last)
			tct_pkg::CH_HOME: begin
				cur_col = 8'd0;
				cur_row = 8'd0;
			end
			tct_pkg::CH_CLEAR: begin
				if (seq_len >= 8'd2 && seq_second == tct_pkg::CH_TWO) begin
					cur_col = 8'd0;
					cur_row = 8'd0;
					return 1'b1;
				end
			end
			tct_pkg::CH_UP:    if (cur_row > 8'd0) cur_row--;
			tct_pkg::CH_DOWN:  if (int'(cur_row) < eff_rows() - 1) cur_row++;
			tct_pkg::CH_RIGHT: if (int'(cur_col) < eff_cols() - 1) cur_col++;
			tct_pkg::CH_LEFT:  if (cur_col > 8'd0) cur_col--;
			default: ;
		endcase
		return 1'b0;
	endfunction

	// Advance the tracker by one terminal byte and return the beat it must produce.
	function automatic tct_pkg::result_t track_byte(logic [7:0] c, logic eow);
		tct_pkg::result_t r;
		int x;
		r = '0;
		if (in_seq) begin
			if (c == tct_pkg::CH_ESC) begin
				// A new escape closes the pending sequence and, unless the write ends,
				// opens another.
				r.clear_request = apply_seq();
				in_seq = 1'b0;
				if (!eow)
					open_seq();
			end else begin
				if (seq_len == 8'd0) seq_first = c;
				if (seq_len == 8'd1) seq_second = c;
				if (seq_len < SEQ_CAP) begin
					seq_last = c;
					seq_len++;
				end
				if (eow) begin
					r.clear_request = apply_seq();
					in_seq = 1'b0;
				end
			end
		end else if (c == tct_pkg::CH_ESC) begin
			if (!eow)
				open_seq();
		end else if (c == tct_pkg::CH_LF) begin
			cur_col = 8'd0;
			r.scroll_up = line_down();
		end else if (c == tct_pkg::CH_CR) begin
			cur_col = 8'd0;
		end else if (c == tct_pkg::CH_BS) begin
			if (cur_col > 8'd0) cur_col--;
		end else if (c == tct_pkg::CH_TAB) begin
			x = (int'(cur_col) + 8) & ~7;
			if (x > eff_cols() - 1)
				x = eff_cols() - 1;
			cur_col = 8'(x);
		end else begin
			r.draw_valid = 1'b1;
			r.draw_byte  = c;
			r.draw_col   = cur_col;
			r.draw_row   = cur_row;
			x = int'(cur_col) + 1;
			if (x >= eff_cols()) begin
				cur_col = 8'd0;
				r.scroll_up = line_down();
			end else begin
				cur_col = 8'(x);
			end
		end
		r.cursor_col_out = cur_col;
		r.cursor_row_out = cur_row;
		glyphs += r.draw_valid;
		scrolls += r.scroll_up;
		clears += r.clear_request;
		return r;
	endfunction

	function automatic string show_beat(tct_pkg::result_t r);
		return $sformatf("draw=%0b byte=%h at (%0d,%0d) scroll=%0b clear=%0b cursor=(%0d,%0d)",
			r.draw_valid, r.draw_byte, r.draw_col, r.draw_row, r.scroll_up,
			r.clear_request, r.cursor_col_out, r.cursor_row_out);
	endfunction

	// ------------------------------------------------------------------
	// Input driver: present queued bytes, predict each one on acceptance,
	// then wait a random delay (none while steady) before offering the next.
	// ------------------------------------------------------------------
	int unsigned send_wait = 0;
	term_byte_t  next_byte;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= 8'd0;
			s_tlast  <= 1'b0;
			send_wait = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				cursor_reports.push_back(track_byte(s_tdata, s_tlast));
				accepted_bytes++;
				send_wait = steady ? 0 : $urandom_range(0, 10);
			end
			// Hold the current beat while the block stalls; otherwise load the next one.
			if (!s_tvalid || s_tready) begin
				if (send_wait > 0) begin
					send_wait--;
					s_tvalid <= 1'b0;
				end else if (tx_bytes.size() != 0) begin
					next_byte = tx_bytes.pop_front();
					s_tdata  <= next_byte.ch;
					s_tlast  <= next_byte.eow;
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Output monitor: compare each result beat with the oldest prediction,
	// stall for a random delay between beats (none while steady), and once hold off for a long
	// stretch while the sender keeps pushing so the block backs up into its input.
	// ------------------------------------------------------------------
	int unsigned      recv_wait = 0;
	int unsigned      hold_cnt = 0;
	bit               held = 1'b0;
	tct_pkg::result_t got_beat;
	tct_pkg::result_t want_beat;
	logic [8:0]       field_err;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			recv_wait = 0;
			hold_cnt = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got_beat.draw_valid     = m_tuser;
				got_beat.draw_byte      = m_tdata[7:0];
				got_beat.draw_col       = m_tdata[15:8];
				got_beat.draw_row       = m_tdata[23:16];
				got_beat.scroll_up      = m_tdata[24];
				got_beat.clear_request  = m_tdata[25];
				got_beat.cursor_col_out = m_tdata[33:26];
				got_beat.cursor_row_out = m_tdata[41:34];
				if (cursor_reports.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("[%0t] unexpected result beat: %s", $realtime,
							show_beat(got_beat));
				end else begin
					want_beat = cursor_reports.pop_front();
					field_err = {
						got_beat.draw_valid     !== want_beat.draw_valid,
						got_beat.draw_byte      !== want_beat.draw_byte,
						got_beat.draw_col       !== want_beat.draw_col,
						got_beat.draw_row       !== want_beat.draw_row,
						got_beat.scroll_up      !== want_beat.scroll_up,
						got_beat.clear_request  !== want_beat.clear_request,
						got_beat.cursor_col_out !== want_beat.cursor_col_out,
						got_beat.cursor_row_out !== want_beat.cursor_row_out,
						m_tdata[47:42]          !== 6'd0
					};
					if (field_err != 9'd0) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("[%0t] result %0d mismatch (fields %b, pad %h)", $realtime,
								results_seen, field_err, m_tdata[47:42]);
							$display("    expected %s", show_beat(want_beat));
							$display("    actual   %s", show_beat(got_beat));
						end
					end
				end
				results_seen++;
				recv_wait = steady ? 0 : $urandom_range(0, 10);
			end
			// One long hold-off once plenty of input is still queued behind it.
			if (!held && results_seen >= 150 && tx_bytes.size() > 8) begin
				hold_cnt = HOLD_LEN;
				held = 1'b1;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				m_tready <= 1'b0;
			end else if (recv_wait > 0) begin
				recv_wait--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Watchdog: give up when no beat moves on any port for too long.
	int unsigned idle_cycles = 0;

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("[%0t] timeout: no beat for %0d cycles, %0d of %0d bytes accepted",
				$realtime, IDLE_LIMIT, accepted_bytes, queued_bytes);
			$display("    %0d results", results_seen);
			$display("Some tests failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	task automatic push_byte(logic [7:0] c, logic eow);
		tx_bytes.push_back('{ch: c, eow: eow});
		queued_bytes++;
	endtask

	// Program one size register over APB; pwdata carries random junk above the low byte.
	task automatic write_size(logic idx, logic [7:0] value);
		logic [31:0] junk;
		junk = $urandom;
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {junk[31:8], value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == tct_pkg::REG_ROWS)
			rows_cfg = value;
		else
			cols_cfg = value;
		size_writes++;
	endtask

	// Wait until every queued byte is in and every prediction has been matched,
	// then let the two-stage pipe settle.
	task automatic wait_drained();
		do @(negedge clk); while (accepted_bytes != queued_bytes || cursor_reports.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	function automatic logic [7:0] pick_final();
		case ($urandom_range(0, 6))
			0: return tct_pkg::CH_HOME;
			1: return tct_pkg::CH_CLEAR;
			2: return tct_pkg::CH_UP;
			3: return tct_pkg::CH_DOWN;
			4: return tct_pkg::CH_RIGHT;
			5: return tct_pkg::CH_LEFT;
			default: return 8'($urandom_range(8'h40, 8'h7E));
		endcase
	endfunction

	// Mostly well-formed traffic: text runs, cursor controls, CSI sequences,
	// a few over-long sequences, and raw noise with random write ends.
	task automatic gen_traffic(int unsigned budget);
		int unsigned start;
		int unsigned kind;
		int unsigned n;
		int unsigned k;
		logic [7:0]  b;
		start = queued_bytes;
		while (queued_bytes - start < budget) begin
			kind = $urandom_range(0, 99);
			if (kind < 35) begin
				n = $urandom_range(1, 12);
				repeat (n) begin
					b = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(32, 126));
					if (b == tct_pkg::CH_ESC)
						b = tct_pkg::CH_HOME;
					push_byte(b, $urandom_range(0, 7) == 0);
				end
			end else if (kind < 47) begin
				case ($urandom_range(0, 3))
					0: push_byte(tct_pkg::CH_LF, 1'b0);
					1: push_byte(tct_pkg::CH_CR, 1'b0);
					2: push_byte(tct_pkg::CH_BS, 1'b0);
					default: push_byte(tct_pkg::CH_TAB, 1'b0);
				endcase
			end else if (kind < 53) begin
				// Jump far with a burst of tabs or line feeds.
				b = $urandom_range(0, 1) ? tct_pkg::CH_TAB : tct_pkg::CH_LF;
				repeat ($urandom_range(4, 16)) push_byte(b, 1'b0);
			end else if (kind < 83) begin
				push_byte(tct_pkg::CH_ESC, 1'b0);
				push_byte(($urandom_range(0, 9) != 0) ? tct_pkg::CH_CSI
					: 8'($urandom_range(32, 126)), 1'b0);
				n = $urandom_range(0, 2);
				for (k = 0; k < n; k++)
					push_byte((k == 0 && $urandom_range(0, 1)) ? tct_pkg::CH_TWO
						: 8'($urandom_range(8'h30, 8'h3B)), 1'b0);
				b = pick_final();
				k = $urandom_range(0, 19);
				if (k < 12) begin
					push_byte(b, 1'b1);
				end else begin
					// Close with the next escape; sometimes that escape opens a new sequence.
					push_byte(b, 1'b0);
					push_byte(tct_pkg::CH_ESC, k < 17);
				end
			end else if (kind < 88) begin
				// Long, often over-long sequence: once 31 bytes are collected, the 31st is the one that counts.
				push_byte(tct_pkg::CH_ESC, 1'b0);
				push_byte(tct_pkg::CH_CSI, 1'b0);
				n = $urandom_range(26, 40);
				for (k = 0; k < n; k++) begin
					b = 8'($urandom);
					if (b == tct_pkg::CH_ESC)
						b = tct_pkg::CH_UP;
					if (k == 29 || (k == n - 1 && $urandom_range(0, 1)))
						b = pick_final();
					push_byte(b, k == n - 1);
				end
			end else begin
				repeat ($urandom_range(1, 4)) push_byte(8'($urandom), $urandom_range(0, 1) == 1);
			end
		end
	endtask

	logic [7:0] size_rows[8] = '{8'd25, 8'd1, 8'd255, 8'd0, 8'd3, 8'd255, 8'd1, 8'd6};
	logic [7:0] size_cols[8] = '{8'd80, 8'd1, 8'd255, 8'd0, 8'd10, 8'd1, 8'd255, 8'd7};

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed bytes at the reset screen size of 25 x 80.
		push_byte(8'h41, 1'b0);                  // plain glyph
		push_byte(8'h00, 1'b0);                  // zero byte is drawn
		push_byte(8'hFF, 1'b1);                  // top byte, end of write on a glyph
		push_byte(tct_pkg::CH_TAB, 1'b0);
		push_byte(tct_pkg::CH_BS, 1'b0);
		push_byte(tct_pkg::CH_CR, 1'b0);
		push_byte(tct_pkg::CH_BS, 1'b0);         // backspace at column zero
		push_byte(tct_pkg::CH_LF, 1'b0);
		push_byte(tct_pkg::CH_ESC, 1'b0);        // clear screen, ended by end of write
		push_byte(tct_pkg::CH_CSI, 1'b0);
		push_byte(tct_pkg::CH_TWO, 1'b0);
		push_byte(tct_pkg::CH_CLEAR, 1'b1);
		push_byte(tct_pkg::CH_ESC, 1'b0);        // down, ended by the next escape
		push_byte(tct_pkg::CH_CSI, 1'b0);
		push_byte(tct_pkg::CH_DOWN, 1'b0);
		push_byte(tct_pkg::CH_ESC, 1'b0);        // that escape opens the right move
		push_byte(tct_pkg::CH_CSI, 1'b0);
		push_byte(tct_pkg::CH_RIGHT, 1'b0);
		push_byte(tct_pkg::CH_ESC, 1'b1);        // escape with end of write closes, opens nothing
		push_byte(tct_pkg::CH_ESC, 1'b1);        // idle escape with end of write
		push_byte(tct_pkg::CH_ESC, 1'b0);        // empty sequence
		push_byte(tct_pkg::CH_ESC, 1'b0);
		push_byte(tct_pkg::CH_CSI, 1'b0);        // control and zero bytes collected inside
		push_byte(tct_pkg::CH_LF, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(tct_pkg::CH_LEFT, 1'b1);
		push_byte(tct_pkg::CH_ESC, 1'b0);
		push_byte(tct_pkg::CH_CSI, 1'b0);
		push_byte(tct_pkg::CH_UP, 1'b0);
		push_byte(tct_pkg::CH_ESC, 1'b0);
		push_byte(tct_pkg::CH_CSI, 1'b0);
		push_byte(tct_pkg::CH_HOME, 1'b1);

		// Random traffic across screen sizes; the sender pauses for a full drain
		// before each size change. Screen sizes swing between big and small so the
		// cursor is often left outside a freshly shrunken screen.
		for (int p = 0; p < 8; p++) begin
			wait_drained();
			steady = 1'b0;
			write_size(tct_pkg::REG_ROWS, size_rows[p]);
			write_size(tct_pkg::REG_COLS, size_cols[p]);
			@(negedge clk);
			steady = (p % 3 == 2);
			gen_traffic(60);
		end

		wait_drained();
		repeat (8) @(negedge clk);
		if (cursor_reports.size() != 0) begin
			$display("%0d predicted beats never arrived", cursor_reports.size());
			mismatches += cursor_reports.size();
		end
		$display("Sent %0d terminal bytes over %0d size register writes; checked %0d results",
			accepted_bytes, size_writes, results_seen);
		$display("  with %0d glyphs, %0d scroll requests, %0d clear requests, %0d mismatches",
			glyphs, scrolls, clears, mismatches);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// File: terminal_cursor_tracker.f
rtl/tct_pkg.sv
rtl/tct_cfg_regs.sv
rtl/tct_step.sv
rtl/terminal_cursor_tracker.sv
sim/terminal_cursor_tracker_tb.sv
